// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks of the DTMF decoder. Each macro
// samples on the rising edge of clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DTMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define DTMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dtmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF decoder package
// Widths, tone tables, keypad map and the request structs shared by the cells
// and the top level.
// ----------------------------------------------------------------------------
package dtmf_pkg;

  localparam int BLOCK_LEN = 50;
  localparam int NUM_BINS  = 8;
  localparam int ROM_WORDS = NUM_BINS * BLOCK_LEN;
  localparam int GROUP_LEN = 4;

  localparam int SAMPLE_W = 8;
  localparam int COEF_W   = 8;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 21;
  localparam int ENERGY_W = ACC_W + 1;
  localparam int POS_W    = $clog2(BLOCK_LEN);
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int GIDX_W   = $clog2(GROUP_LEN);
  localparam int ADDR_W   = $clog2(ROM_WORDS);
  localparam int KEY_W    = 7;

  // Sample token that travels down the chain of bin cells.
  typedef struct packed {
    logic                       valid;
    logic                       last;
    logic [POS_W-1:0]           pos;
    logic signed [SAMPLE_W-1:0] sample;
  } token_t;

  // Running winner of a tone group, handed from cell to cell.
  typedef struct packed {
    logic                valid;
    logic [ENERGY_W-1:0] energy;
    logic [GIDX_W-1:0]   idx;
    logic [GIDX_W-1:0]   row;
  } best_t;

  localparam logic [COEF_W-1:0] COS_ROM [ROM_WORDS] = '{
    8'h7E,8'h3A,8'hB7,8'h83,8'hD7,8'h57,8'h79,8'h18,8'h9D,8'h8D,8'hFA,8'h6D,8'h6A,8'hF4,
    8'h8B,8'hA1,8'h1E,8'h7A,8'h52,8'hD1,8'h83,8'hBC,8'h3F,8'h7E,8'h34,8'hB2,8'h84,8'hDD,
    8'h5B,8'h77,8'h12,8'h99,8'h90,8'h00,8'h70,8'h67,8'hEE,8'h89,8'hA5,8'h24,
    8'h7C,8'h4E,8'hCB,8'h82,8'hC1,8'h44,8'h7D,8'h2F,8'hAD,8'h86,8'h7E,8'h2D,8'hA1,8'h91,
    8'h10,8'h7B,8'h47,8'hB8,8'h86,8'hF2,8'h70,8'h5D,8'hD2,8'h82,8'hD5,8'h60,8'h6E,8'hEE,
    8'h85,8'hBB,8'h4A,8'h7A,8'h0C,8'h8F,8'hA4,8'h30,8'h7E,8'h29,8'h9F,8'h93,
    8'h14,8'h7B,8'h44,8'hB4,8'h87,8'hF6,8'h72,8'h5A,8'hCE,8'h82,8'hD9,8'h62,8'h6C,8'hEA,
    8'h84,8'hBE,8'h4D,8'h78,8'h08,8'h8D,8'h7E,8'h1D,8'h8F,8'hAF,8'h4B,8'h74,8'hEA,8'h82,
    8'hDC,8'h6D,8'h56,8'hBA,8'h8A,8'h0F,8'h7D,8'h2B,8'h96,8'hA5,8'h3F,8'h79,
    8'hF8,8'h84,8'hCF,8'h65,8'h60,8'hC7,8'h86,8'h01,8'h7B,8'h38,8'h9F,8'h9B,8'h33,8'h7C,
    8'h06,8'h87,8'hC2,8'h5C,8'h69,8'hD4,8'h83,8'hF3,8'h77,8'h44,8'hA9,8'h94,8'h25,8'h7E,
    8'h14,8'h8C,8'h7E,8'h0C,8'h84,8'hDD,8'h75,8'h38,8'h95,8'hB4,8'h5D,8'h5D,
    8'hB4,8'h95,8'h38,8'h76,8'hDE,8'h84,8'h0B,8'h7E,8'h0C,8'h84,8'hDD,8'h75,8'h39,8'h95,
    8'hB3,8'h5D,8'h5E,8'hB5,8'h94,8'h37,8'h76,8'hDF,8'h84,8'h0A,8'h7E,8'h0D,8'h84,8'hDC,
    8'h75,8'h39,8'h96,8'hB3,8'h5C,8'h5E,8'hB5,8'h94,8'h37,8'h76,8'hDF,8'h84,
    8'h7E,8'hD7,8'h9C,8'h69,8'h20,8'h82,8'h31,8'h5E,8'h92,8'hE9,8'h7D,8'hC7,8'hA8,8'h72,
    8'h0F,8'h85,8'h41,8'h51,8'h8B,8'hFA,8'h79,8'hB8,8'hB6,8'h78,8'hFD,8'h8A,8'h4F,8'h43,
    8'h85,8'h0C,8'h73,8'hAA,8'hC5,8'h7C,8'hEB,8'h91,8'h5C,8'h33,8'h83,8'h1E,
    8'h6A,8'h9E,8'hD5,8'h7E,8'hDA,8'h9B,8'h68,8'h23,8'h82,8'h2F,8'h7E,8'hC1,8'hC2,8'h7E,
    8'hBF,8'hC3,8'h7E,8'hBE,8'hC5,8'h7E,8'hBC,8'hC6,8'h7E,8'hBB,8'hC8,8'h7E,8'hBA,8'hC9,
    8'h7E,8'hB9,8'hCA,8'h7E,8'hB7,8'hCC,8'h7D,8'hB6,8'hCD,8'h7D,8'hB5,8'hCF,
    8'h7D,8'hB3,8'hD0,8'h7D,8'hB2,8'hD2,8'h7D,8'hB1,8'hD3,8'h7C,8'hB0,8'hD5,8'h7C,8'hAE,
    8'hD6,8'h7C,8'hAD,8'hD8,8'h7B,8'hAC,8'h7E,8'hAA,8'hF7,8'h62,8'h83,8'h48,8'h1B,8'h93,
    8'h79,8'hC8,8'hD3,8'h75,8'h8E,8'h27,8'h3D,8'h86,8'h6A,8'hEB,8'hB4,8'h7D,
    8'hA1,8'h03,8'h5A,8'h82,8'h52,8'h0F,8'h9A,8'h7C,8'hBD,8'hDF,8'h6F,8'h89,8'h33,8'h32,
    8'h89,8'h70,8'hDE,8'hBE,8'h7C,8'h9A,8'h10,8'h51,8'h82,8'h5B,8'h02,8'hA2,8'h7D,8'hB3,
    8'hEC,8'h69,8'h7E,8'h96,8'h33,8'h14,8'hAB,8'h7A,8'h88,8'h4F,8'hF3,8'hC6,
    8'h6D,8'h82,8'h65,8'hD4,8'hE5,8'h5A,8'h85,8'h75,8'hB7,8'h05,8'h40,8'h8F,8'h7D,8'h9F,
    8'h25,8'h22,8'hA1,8'h7D,8'h8E,8'h43,8'h02,8'hBA,8'h74,8'h84,8'h5C,8'hE2,8'hD7,8'h63,
    8'h82,8'h6F,8'hC3,8'hF7,8'h4C,8'h89,8'h7B,8'hA9,8'h17,8'h30,8'h98,8'h7E
  };

  localparam logic [COEF_W-1:0] SIN_ROM [ROM_WORDS] = '{
    8'h00,8'h70,8'h67,8'hEE,8'h89,8'hA5,8'h24,8'h7C,8'h4E,8'hCC,8'h82,8'hC1,8'h44,8'h7D,
    8'h2F,8'hAD,8'h86,8'hE2,8'h5F,8'h75,8'h0C,8'h96,8'h93,8'h06,8'h73,8'h63,8'hE8,8'h87,
    8'hA9,8'h29,8'h7D,8'h49,8'hC6,8'h82,8'hC6,8'h49,8'h7D,8'h29,8'hA9,8'h87,
    8'hE8,8'h63,8'h73,8'h06,8'h93,8'h96,8'h0C,8'h75,8'h5F,8'hE2,8'h00,8'h76,8'h53,8'hC5,
    8'h83,8'hE3,8'h68,8'h67,8'hE1,8'h83,8'hC7,8'h55,8'h75,8'hFE,8'h89,8'hAE,8'h3D,8'h7D,
    8'h1B,8'h97,8'h9A,8'h21,8'h7D,8'h37,8'hAA,8'h8C,8'h04,8'h77,8'h50,8'hC2,
    8'h84,8'hE6,8'h6A,8'h65,8'hDD,8'h82,8'hCA,8'h58,8'h74,8'hFA,8'h88,8'hB1,8'h40,8'h7C,
    8'h18,8'h95,8'h9C,8'h25,8'h7E,8'h34,8'h00,8'h7B,8'h38,8'h9F,8'h9B,8'h32,8'h7C,8'h07,
    8'h87,8'hC1,8'h5C,8'h69,8'hD5,8'h83,8'hF2,8'h77,8'h45,8'hA9,8'h93,8'h25,
    8'h7E,8'h15,8'h8C,8'hB5,8'h52,8'h70,8'hE2,8'h82,8'hE4,8'h71,8'h50,8'hB4,8'h8D,8'h17,
    8'h7E,8'h23,8'h92,8'hAA,8'h46,8'h76,8'hF0,8'h83,8'hD6,8'h6A,8'h5B,8'hC0,8'h88,8'h09,
    8'h7C,8'h31,8'h00,8'h7D,8'h17,8'h87,8'hD2,8'h71,8'h43,8'h9C,8'hAB,8'h55,
    8'h65,8'hBE,8'h8F,8'h2D,8'h79,8'hE9,8'h82,8'hFF,8'h7D,8'h18,8'h87,8'hD2,8'h70,8'h43,
    8'h9C,8'hAA,8'h54,8'h65,8'hBF,8'h8F,8'h2D,8'h79,8'hEA,8'h82,8'hFF,8'h7D,8'h18,8'h87,
    8'hD1,8'h70,8'h44,8'h9C,8'hAA,8'h54,8'h65,8'hBF,8'h8F,8'h2C,8'h7A,8'hEB,
    8'h00,8'h77,8'hB3,8'hBA,8'h7A,8'hF7,8'h8C,8'h54,8'h3E,8'h84,8'h12,8'h70,8'hA6,8'hCA,
    8'h7D,8'hE5,8'h94,8'h60,8'h2E,8'h82,8'h23,8'h67,8'h9A,8'hDA,8'h7E,8'hD4,8'h9E,8'h6B,
    8'h1D,8'h83,8'h34,8'h5C,8'h91,8'hEC,8'h7C,8'hC4,8'hAA,8'h73,8'h0B,8'h86,
    8'h44,8'h4F,8'h8A,8'hFD,8'h78,8'hB5,8'hB8,8'h79,8'hFA,8'h8B,8'h00,8'h6D,8'h92,8'h02,
    8'h6C,8'h92,8'h03,8'h6B,8'h91,8'h05,8'h6A,8'h90,8'h06,8'h6A,8'h8F,8'h08,8'h69,8'h8F,
    8'h09,8'h68,8'h8E,8'h0B,8'h67,8'h8D,8'h0D,8'h66,8'h8D,8'h0E,8'h65,8'h8C,
    8'h10,8'h64,8'h8B,8'h11,8'h63,8'h8B,8'h13,8'h62,8'h8A,8'h14,8'h61,8'h8A,8'h16,8'h60,
    8'h89,8'h18,8'h5F,8'h89,8'h19,8'h5E,8'h00,8'h5C,8'h82,8'h4F,8'h12,8'h98,8'h7B,8'hC0,
    8'hDC,8'h71,8'h8A,8'h30,8'h35,8'h88,8'h6E,8'hE2,8'hBB,8'h7C,8'h9C,8'h0C,
    8'h53,8'h82,8'h58,8'h06,8'hA0,8'h7D,8'hB6,8'hE8,8'h6B,8'h86,8'h3B,8'h29,8'h8D,8'h74,
    8'hD6,8'hC6,8'h79,8'h95,8'h19,8'h4A,8'h83,8'h61,8'hF9,8'hA8,8'h7E,8'hAC,8'hF5,8'h64,
    8'h84,8'h46,8'h00,8'h45,8'h8D,8'h7C,8'hA3,8'h20,8'h27,8'h9E,8'h7D,8'h90,
    8'h3E,8'h07,8'hB5,8'h76,8'h85,8'h58,8'hE7,8'hD2,8'h67,8'h82,8'h6C,8'hC8,8'hF1,8'h50,
    8'h88,8'h79,8'hAD,8'h12,8'h35,8'h95,8'h7E,8'h97,8'h31,8'h16,8'hAA,8'h7A,8'h89,8'h4D,
    8'hF5,8'hC5,8'h6E,8'h82,8'h64,8'hD6,8'hE3,8'h5B,8'h84,8'h74,8'hB9,8'h03
  };

  // Keypad characters, row-major: "123A", "456B", "789C", "*0#D".
  localparam logic [KEY_W-1:0] KEYPAD [GROUP_LEN*GROUP_LEN] = '{
    7'h31, 7'h32, 7'h33, 7'h41,
    7'h34, 7'h35, 7'h36, 7'h42,
    7'h37, 7'h38, 7'h39, 7'h43,
    7'h2A, 7'h30, 7'h23, 7'h44
  };

  function automatic logic [ADDR_W-1:0] rom_addr(input logic [BIN_W-1:0] bin,
                                                 input logic [POS_W-1:0] pos);
    rom_addr = ADDR_W'(bin) * ADDR_W'(BLOCK_LEN) + ADDR_W'(pos);
  endfunction

  function automatic logic signed [COEF_W-1:0] cos_word(input logic [BIN_W-1:0] bin,
                                                       input logic [POS_W-1:0] pos);
    cos_word = $signed(COS_ROM[rom_addr(bin, pos)]);
  endfunction

  function automatic logic signed [COEF_W-1:0] sin_word(input logic [BIN_W-1:0] bin,
                                                       input logic [POS_W-1:0] pos);
    sin_word = $signed(SIN_ROM[rom_addr(bin, pos)]);
  endfunction

  function automatic logic [KEY_W-1:0] key_of(input logic [GIDX_W-1:0] row,
                                             input logic [GIDX_W-1:0] col);
    key_of = KEYPAD[{row, col}];
  endfunction

endpackage

// ----- rtl/dtmf_bin_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF bin cell
// One tone bin: correlates each passing sample with its cosine and sine words,
// and at the end of a block folds its magnitude into the group's running
// winner before handing both on to the next cell.
// ----------------------------------------------------------------------------
module dtmf_bin_cell import dtmf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [BIN_W-1:0] bin,
  input  token_t           tok_in,
  output token_t           tok_out,
  input  best_t            best_in,
  output best_t            best_out
);

  logic signed [ACC_W-1:0]    acc_re;
  logic signed [ACC_W-1:0]    acc_im;
  logic                       done;

  logic signed [PROD_W-1:0]   prod_re;
  logic signed [PROD_W-1:0]   prod_im;
  logic signed [ACC_W-1:0]    base_re;
  logic signed [ACC_W-1:0]    base_im;
  logic [ACC_W-1:0]           mag_re;
  logic [ACC_W-1:0]           mag_im;
  logic [ENERGY_W-1:0]        energy;
  logic                       head;
  logic                       take;

  always_comb begin
    if (tok_in.valid) begin
      prod_re = tok_in.sample * cos_word(bin, tok_in.pos);
      prod_im = tok_in.sample * sin_word(bin, tok_in.pos);
    end else begin
      prod_re = '0;
      prod_im = '0;
    end
    // A finished block is read out and cleared in the same cycle.
    base_re = done ? '0 : acc_re;
    base_im = done ? '0 : acc_im;
  end

  always_comb begin
    mag_re = acc_re[ACC_W-1] ? ACC_W'(-acc_re) : ACC_W'(acc_re);
    mag_im = acc_im[ACC_W-1] ? ACC_W'(-acc_im) : ACC_W'(acc_im);
    energy = {1'b0, mag_re} + {1'b0, mag_im};
    head   = (bin[GIDX_W-1:0] == '0);
    // Strict compare so the lower bin keeps a tie.
    take   = head || (energy > best_in.energy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re         <= '0;
      acc_im         <= '0;
      done           <= 1'b0;
      tok_out.valid  <= 1'b0;
      best_out.valid <= 1'b0;
    end else if (en) begin
      acc_re         <= base_re + ACC_W'(prod_re);
      acc_im         <= base_im + ACC_W'(prod_im);
      done           <= tok_in.valid && tok_in.last;
      tok_out.valid  <= tok_in.valid;
      best_out.valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_out.last   <= tok_in.last;
      tok_out.pos    <= tok_in.pos;
      tok_out.sample <= tok_in.sample;
      if (done) begin
        best_out.energy <= take ? energy : best_in.energy;
        best_out.idx    <= take ? bin[GIDX_W-1:0] : best_in.idx;
        best_out.row    <= head ? best_in.idx : best_in.row;
      end
    end
  end

endmodule

// ----- rtl/dtmf_block_dft_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF block DFT decoder
// Correlates blocks of 50 audio samples against eight tone bins and reports
// the key whose row and column tones carry the most energy.
// ----------------------------------------------------------------------------
//
//   channel  signals                              direction  request
//   input    in_valid, in_ready, sample           to block   one audio sample
//   output   out_valid, out_ready, key_char,      from block one decoded key
//            row_index, column_index
//
// One sample is taken per clock while the chain is not stalled. A finished
// block's key passes through the eight bin cells of the chain and then
// leaves the output register.
// Reset is synchronous and clears the sample position, all accumulators and
// every valid flag; the block takes samples in the first cycle after reset.
// The chain stalls as a whole only when a key reaches its end while the
// output register still holds an earlier key that is not being taken.
//
module dtmf_block_dft_decoder_unit import dtmf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [KEY_W-1:0]           key_char,
  output logic [GIDX_W-1:0]          row_index,
  output logic [GIDX_W-1:0]          column_index
);

`include "assert_macros.svh"

  // Position of the next sample within its block.
  logic [POS_W-1:0] pos;
  logic             en;
  logic             accept;
  logic             pend;

  token_t               tok  [NUM_BINS+1];
  best_t                best [NUM_BINS+1];
  logic [NUM_BINS-1:0]  done_vec;

  // The whole chain moves together. It only holds when a finished key is
  // at the end of the chain and the output register cannot take it.
  assign pend     = best[NUM_BINS].valid;
  assign en       = !(pend && out_valid && !out_ready);
  assign in_ready = en;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= (pos == POS_W'(BLOCK_LEN - 1)) ? '0 : pos + 1'b1;
    end
  end

  always_comb begin
    tok[0].valid  = accept;
    tok[0].last   = (pos == POS_W'(BLOCK_LEN - 1));
    tok[0].pos    = pos;
    tok[0].sample = sample;
    best[0]       = '0;
  end

  // Eight bin cells. The row group is bins 0 to 3, the column group bins
  // 4 to 7; the first cell of each group starts a fresh winner, and the
  // column head also latches the row winner so both reach the end together.
  for (genvar b = 0; b < NUM_BINS; b++) begin : g_cell
    dtmf_bin_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .bin      (BIN_W'(b)),
      .tok_in   (tok[b]),
      .tok_out  (tok[b+1]),
      .best_in  (best[b]),
      .best_out (best[b+1])
    );
    assign done_vec[b] = best[b+1].valid;
  end

  // Output register. It is loaded only when free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend && en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && en) begin
      key_char     <= key_of(best[NUM_BINS].row, best[NUM_BINS].idx);
      row_index    <= best[NUM_BINS].row;
      column_index <= best[NUM_BINS].idx;
    end
  end

  // The position counter never reaches the block length.
  `DTMF_ASSERT(a_pos_range, pos < POS_W'(BLOCK_LEN), "sample position out of range")

  // Blocks are at least fifty samples apart, so at most one result is in flight.
  `DTMF_ASSERT(a_one_result, $onehot0(done_vec), "more than one result in the chain")

  // The input side only stalls behind a held key.
  `DTMF_ASSERT(a_stall_cause, !in_ready |-> (out_valid && pend), "stall without held key")

  // Taking the last sample of a block restarts the position.
  `DTMF_ASSERT_NEXT(a_wrap, accept && (pos == POS_W'(BLOCK_LEN - 1)), pos == '0,
                    "position did not wrap")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF block DFT decoder testbench
// Feeds frames of audio samples through the valid/ready input, predicts the
// key of every 50-sample frame with an independent eight-bin correlator and
// checks each decoded key, row and column as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
  import dtmf_pkg::*;

  localparam int FRAME_LEN     = 50;
  localparam int TONES         = 8;
  localparam int TAB_WORDS     = FRAME_LEN * TONES;
  localparam int RANDOM_FRAMES = 23;
  localparam int HOLD_AT       = 600;   // samples taken before the long output stall
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;  // cycles without any handshake
  localparam int DRAIN_CYCLES  = 30;
  localparam int REPORT_MAX    = 10;
  localparam int CALM_FROM     = 1200;  // window with no idling on either side
  localparam int CALM_TO       = 2000;

  // Correlation tables, one byte per word, word 0 in the top byte. Word
  // address is tone bin times the frame length plus the sample position.
  localparam logic [8*TAB_WORDS-1:0] COS_TAB = {
    320'h7E3AB783D7577918_9D8DFA6D6AF48BA1_1E7A52D183BC3F7E_34B284DD5B771299_90007067EE89A524,
    320'h7C4ECB82C1447D2F_AD867E2DA191107B_47B886F2705DD282_D5606EEE85BB4A7A_0C8FA4307E299F93,
    320'h147B44B487F6725A_CE82D9626CEA84BE_4D78088D7E1D8FAF_4B74EA82DC6D56BA_8A0F7D2B96A53F79,
    320'hF884CF6560C78601_7B389F9B337C0687_C25C69D483F37744_A994257E148C7E0C_84DD753895B45D5D,
    320'hB4953876DE840B7E_0C84DD753995B35D_5EB5943776DF840A_7E0D84DC753996B3_5C5EB5943776DF84,
    320'h7ED79C692082315E_92E97DC7A8720F85_41518BFA79B8B678_FD8A4F43850C73AA_C57CEB915C33831E,
    320'h6A9ED57EDA9B6823_822F7EC1C27EBFC3_7EBEC57EBCC67EBB_C87EBAC97EB9CA7E_B7CC7DB6CD7DB5CF,
    320'h7DB3D07DB2D27DB1_D37CB0D57CAED67C_ADD87BAC7EAAF762_83481B9379C8D375_8E273D866AEBB47D,
    320'hA1035A82520F9A7C_BDDF6F8933328970_DEBE7C9A1051825B_02A27DB3EC697E96_3314AB7A884FF3C6,
    320'h6D8265D4E55A8575_B705408F7D9F2522_A17D8E4302BA7484_5CE2D763826FC3F7_4C897BA91730987E
  };

  localparam logic [8*TAB_WORDS-1:0] SIN_TAB = {
    320'h007067EE89A5247C_4ECC82C1447D2FAD_86E25F750C969306_7363E887A9297D49_C682C6497D29A987,
    320'hE863730693960C75_5FE2007653C583E3_6867E183C75575FE_89AE3D7D1B979A21_7D37AA8C047750C2,
    320'h84E66A65DD82CA58_74FA88B1407C1895_9C257E34007B389F_9B327C0787C15C69_D583F27745A99325,
    320'h7E158CB55270E282_E47150B48D177E23_92AA4676F083D66A_5BC088097C31007D_1787D271439CAB55,
    320'h65BE8F2D79E982FF_7D1887D270439CAA_5465BF8F2D79EA82_FF7D1887D170449C_AA5465BF8F2C7AEB,
    320'h0077B3BA7AF78C54_3E841270A6CA7DE5_94602E8223679ADA_7ED49E6B1D83345C_91EC7CC4AA730B86,
    320'h444F8AFD78B5B879_FA8B006D92026C92_036B91056A90066A_8F08698F09688E0B_678D0D668D0E658C,
    320'h10648B11638B1362_8A14618A16608918_5F89195E005C824F_12987BC0DC718A30_35886EE2BB7C9C0C,
    320'h53825806A07DB6E8_6B863B298D74D6C6_7995194A8361F9A8_7EACF56484460045_8D7CA320279E7D90,
    320'h3E07B5768558E7D2_67826CC8F1508879_AD1235957E973116_AA7A894DF5C56E82_64D6E35B8474B903
  };

  // Keypad glyphs, row-major, first glyph in the top byte.
  localparam logic [8*16-1:0] KEY_GLYPHS = "123A456B789C*0#D";

  typedef struct packed {
    logic [KEY_W-1:0]  glyph;
    logic [GIDX_W-1:0] row;
    logic [GIDX_W-1:0] col;
  } key_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [KEY_W-1:0]           key_char;
  logic [GIDX_W-1:0]          row_index;
  logic [GIDX_W-1:0]          column_index;

  dtmf_block_dft_decoder_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_char     (key_char),
    .row_index    (row_index),
    .column_index (column_index)
  );

  // Samples still to be offered, and keys the correlator has predicted but
  // the block has not yet delivered.
  logic signed [SAMPLE_W-1:0] sample_q[$];
  key_t                       key_q[$];

  // Correlator state: one real and one imaginary sum per tone bin.
  logic signed [20:0] re_acc [TONES];
  logic signed [20:0] im_acc [TONES];
  logic [5:0]         frame_pos;

  int        samples_taken = 0;
  int        keys_checked = 0;
  int        mismatches = 0;
  int        cyc = 0;
  int        quiet = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  logic [15:0] keys_seen = '0;
  logic      calm;

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [7:0] cos_coef(input int idx);
    return COS_TAB[(TAB_WORDS-1-idx)*8 +: 8];
  endfunction

  function automatic logic signed [7:0] sin_coef(input int idx);
    return SIN_TAB[(TAB_WORDS-1-idx)*8 +: 8];
  endfunction

  // Adds one accepted sample into all sixteen sums. On the last sample of a
  // frame it picks the strongest row bin and the strongest column bin (the
  // lower bin keeps the lead on equal energy), queues the key and clears.
  task automatic dft_step(input logic signed [SAMPLE_W-1:0] s);
    int   energy [TONES];
    int   re_mag, im_mag, addr;
    int   row_win, col_win;
    key_t k;
    for (int b = 0; b < TONES; b++) begin
      addr = b * FRAME_LEN + int'(frame_pos);
      re_acc[b] = re_acc[b] + 21'(int'(s) * int'(cos_coef(addr)));
      im_acc[b] = im_acc[b] + 21'(int'(s) * int'(sin_coef(addr)));
    end
    if (frame_pos != 6'(FRAME_LEN - 1)) begin
      frame_pos = frame_pos + 6'd1;
    end else begin
      for (int b = 0; b < TONES; b++) begin
        re_mag = (re_acc[b] < 0) ? -int'(re_acc[b]) : int'(re_acc[b]);
        im_mag = (im_acc[b] < 0) ? -int'(im_acc[b]) : int'(im_acc[b]);
        energy[b] = re_mag + im_mag;
      end
      row_win = 0;
      col_win = 4;
      for (int b = 1; b < 4; b++) begin
        if (energy[b] > energy[row_win]) row_win = b;
      end
      for (int b = 5; b < 8; b++) begin
        if (energy[b] > energy[col_win]) col_win = b;
      end
      k.row   = GIDX_W'(row_win);
      k.col   = GIDX_W'(col_win - 4);
      k.glyph = KEY_GLYPHS[(15 - (row_win * 4 + col_win - 4)) * 8 +: KEY_W];
      key_q.push_back(k);
      for (int b = 0; b < TONES; b++) begin
        re_acc[b] = '0;
        im_acc[b] = '0;
      end
      frame_pos = '0;
    end
  endtask

  function automatic logic signed [7:0] clip8(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return 8'(v);
  endfunction

  // A dual-tone frame: random cosine and sine weights on one row bin and one
  // column bin, plus uniform noise. Loud weights drive the samples into
  // clipping at both rails.
  task automatic queue_tone_frame(input int row, input int col, input int noise_span);
    int wrc, wrs, wcc, wcs, acc, ri, ci;
    wrc = int'($urandom_range(0, 64)) - 32;
    wrs = int'($urandom_range(0, 64)) - 32;
    wcc = int'($urandom_range(0, 64)) - 32;
    wcs = int'($urandom_range(0, 64)) - 32;
    for (int p = 0; p < FRAME_LEN; p++) begin
      ri  = row * FRAME_LEN + p;
      ci  = (4 + col) * FRAME_LEN + p;
      acc = wrc * int'(cos_coef(ri)) + wrs * int'(sin_coef(ri))
          + wcc * int'(cos_coef(ci)) + wcs * int'(sin_coef(ci));
      acc = (acc >>> 6) + int'($urandom_range(0, 2 * noise_span)) - noise_span;
      sample_q.push_back(clip8(acc));
    end
  endtask

  // Frame with a fixed value at every position, or two values alternating.
  task automatic queue_flat_frame(input logic signed [7:0] even, input logic signed [7:0] odd);
    for (int p = 0; p < FRAME_LEN; p++) begin
      sample_q.push_back((p % 2 == 0) ? even : odd);
    end
  endtask

  // Compares one delivered key with the oldest prediction.
  task automatic check_key();
    key_t want;
    if (key_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("tb: key '%c' row %0d column %0d delivered with none predicted",
                 key_char, row_index, column_index);
      end
    end else begin
      want = key_q.pop_front();
      keys_checked++;
      if (key_char !== want.glyph || row_index !== want.row || column_index !== want.col) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("tb: key %0d: expected '%c' row %0d column %0d, got '%c' row %0d column %0d",
                   keys_checked, want.glyph, want.row, want.col,
                   key_char, row_index, column_index);
        end
      end else begin
        keys_seen[{row_index, column_index}] = 1'b1;
      end
    end
  endtask

  // Sample request driver. A request stays up with its sample unchanged
  // until the block takes it; only then does the next one get pulled from
  // the queue, or the line drops for an idle cycle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        dft_step(sample);
        samples_taken <= samples_taken + 1;
      end
      if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
        in_valid <= 1'b1;
        sample   <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Key request monitor. Ready is dropped at random, and held low for the
  // whole of the long stall below.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_key();
      out_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 35);
    end
  end

  // Once, partway through, the key side refuses requests for a long stretch
  // while samples keep coming, so the output register and the bin chain fill
  // and the block has to push back on its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && samples_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Watchdog: ends the run when neither channel moves a request for too long.
  always @(posedge clk) begin
    if (rst) begin
      cyc   <= 0;
      quiet <= 0;
    end else begin
      cyc <= cyc + 1;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
        $display("tb: no request moved for %0d cycles, %0d keys outstanding",
                 quiet, key_q.size());
        $display("tb: errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int row, col;
    for (int b = 0; b < TONES; b++) begin
      re_acc[b] = '0;
      im_acc[b] = '0;
    end
    frame_pos = '0;

    // Silence: every bin has zero energy, so the lowest row and column win.
    queue_flat_frame(8'sd0, 8'sd0);
    // Both rails held for a frame, then alternating between them.
    queue_flat_frame(8'sd127, 8'sd127);
    queue_flat_frame(-8'sd128, -8'sd128);
    queue_flat_frame(8'sd127, -8'sd128);
    // A lone impulse at position zero: every bin of both groups sees the
    // same energy, so the lowest bin of each group must win.
    sample_q.push_back(8'sd127);
    for (int p = 1; p < FRAME_LEN; p++) sample_q.push_back(8'sd0);

    // Random frames: every key once as a lightly noisy tone pair, then noisy tone
    // pairs on random keys with some frames of pure noise mixed in.
    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      if (n < 16) begin
        queue_tone_frame(n / 4, n % 4, 4);
      end else if ($urandom_range(0, 3) != 0) begin
        row = $urandom_range(0, 3);
        col = $urandom_range(0, 3);
        queue_tone_frame(row, col, $urandom_range(0, 40));
      end else begin
        for (int p = 0; p < FRAME_LEN; p++) sample_q.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (sample_q.size() != 0 || in_valid) @(posedge clk);
    while (key_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d samples taken, %0d keys checked, %0d mismatches",
             samples_taken, keys_checked, mismatches);
    $display("tb: %0d of 16 keypad keys decoded correctly at least once, input stall forced %0s",
             $countones(keys_seen), hold_done ? "once" : "never");
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
